FILE: src/pwg_pkg.sv
// Package for the periodic waveform generator.
// Holds sizing constants, register and waveform codes, the controller/datapath
// command and status structs, and the elaboration-time quarter-sine table.
package pwg_pkg;

   // Sizing
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int PHASE_BITS       = 32;
   localparam int TAB_IDX_W        = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int UP_SHIFT         = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int DOWN_SHIFT       = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;
   localparam int STEP_W           = 32 - DOWN_SHIFT;
   localparam int MUL_W            = 16 + STEP_W;

   // Interface widths
   localparam int TICKS_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Fixed-point constants
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] FULL_SCALE  = 64'd32768;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP = 4'd0,
      CSR_WAVE_TYPE  = 4'd1,
      CSR_AMPLITUDE  = 4'd2,
      CSR_AVERAGE    = 4'd3
   } csr_index_type;

   // Waveform codes
   typedef enum logic [2:0] {
      WAVE_ZERO     = 3'd0,
      WAVE_SINE     = 3'd1,
      WAVE_SQUARE   = 3'd2,
      WAVE_TRIANGLE = 3'd3,
      WAVE_SAWTOOTH = 3'd4
   } wave_code_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic mul_en;    // capture ticks * step on input transfer
      logic acc_en;    // advance the phase accumulator
      logic wave_en;   // evaluate the waveform at the new phase
      logic scale_en;  // wave * amplitude
      logic load_en;   // round, offset, saturate into the output register
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic out_stall; // output register holds a sample not yet taken
   } status_type;

   typedef logic [16:0] sine_tab_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave sine, Q30 Taylor series to the 11th power, rounded to 1.0 = 32768
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  a;
      logic [63:0]  a2;
      logic [63:0]  term;
      logic [63:0]  e;
      longint       sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         a    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         a2   = (a * a) >> 30;
         sum  = longint'(a);
         term = ((a * a2) >> 30) / 6;
         sum  = sum - longint'(term);
         term = ((term * a2) >> 30) / 20;
         sum  = sum + longint'(term);
         term = ((term * a2) >> 30) / 42;
         sum  = sum - longint'(term);
         term = ((term * a2) >> 30) / 72;
         sum  = sum + longint'(term);
         term = ((term * a2) >> 30) / 110;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         e = ((64'(sum) * FULL_SCALE) + (64'd1 << 29)) >> 30;
         if (e > FULL_SCALE) begin
            e = FULL_SCALE;
         end
         tab[k] = 17'(e);
      end
      return tab;
   endfunction

endpackage

FILE: src/pwg_if.sv
// Channel interfaces of the periodic waveform generator.
// Depends on pwg_pkg for the payload widths.

// Sample request channel
interface pwg_req_if;
   logic                         valid;
   logic                         ready;
   logic [pwg_pkg::TICKS_W-1:0]  ticks_elapsed;
   modport source (output valid, output ticks_elapsed, input ready);
   modport sink   (input valid, input ticks_elapsed, output ready);
endinterface

// Sample result channel
interface pwg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pwg_pkg::SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Register write channel
interface pwg_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pwg_pkg::CSR_INDEX_W-1:0]  index;
   logic [pwg_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/periodic_waveform_generator.sv
// Periodic waveform generator (DDS function generator), top level.
// Usage:
//   csr_ch: register writes (0 phase_step, 1 wave_type, 2 amplitude,
//     3 average); always ready; write only while no request is in flight.
//   req_ch: one transfer per sample request, carrying ticks_elapsed.
//   rsp_ch: one transfer per request, carrying the saturated sample.
// Sequence: the tick multiply is captured at the request transfer, then phase
//   add, wave shaping, amplitude multiply, and round and saturate take one
//   sequencer step each before rsp_ch.valid rises.
// Flow: the sequencer takes one request at a time and req_ch.ready is high
//   only while it is idle.
// Reset: the configuration registers, the phase and the output valid clear
//   to zero; the first phase is the start of a cycle.
// Stall: the finished sample sits in an output register, so the next request
//   is taken while it waits; that request holds in its last step until the
//   register is free.
// Depends on pwg_pkg, the channel interfaces, pwg_ctrl and pwg_datapath.
module periodic_waveform_generator (
   input  logic      clock,
   input  logic      reset,
   pwg_req_if.sink   req_ch,
   pwg_rsp_if.source rsp_ch,
   pwg_csr_if.sink   csr_ch
);

   pwg_pkg::cmd_type    cmd;
   pwg_pkg::status_type status;
   logic                req_ready;

   assign req_ch.ready = req_ready;

   pwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pwg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ticks_elapsed (req_ch.ticks_elapsed),
      .cmd           (cmd),
      .status        (status),
      .csr           (csr_ch),
      .rsp           (rsp_ch)
   );

   // A request transfer puts the sequencer to work for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while a request is in flight");

   // A load presents a sample in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |=> rsp_ch.valid)
      else $error("loaded sample not presented");

   // Never overwrite a sample that is stalled at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("output register overwritten while stalled");

   // Only one stage of the datapath is busy at a time
   a_one_stage: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mul_en, cmd.acc_en, cmd.wave_en, cmd.scale_en, cmd.load_en}))
      else $error("several datapath stages enabled at once");

endmodule

FILE: src/pwg_ctrl.sv
// Sequencer of the periodic waveform generator.
// Steps one request through the datapath stages. Depends on pwg_pkg.
module pwg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pwg_pkg::status_type status,
   output pwg_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_WAVE,
      ST_SCALE,
      ST_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer) state_in = ST_ACCUM;
         ST_ACCUM: state_in = ST_WAVE;
         ST_WAVE:  state_in = ST_SCALE;
         ST_SCALE: state_in = ST_LOAD;
         ST_LOAD:  if (!status.out_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Stage commands
   always_comb begin
      cmd          = '0;
      cmd.mul_en   = req_xfer;
      cmd.acc_en   = (state_ff == ST_ACCUM);
      cmd.wave_en  = (state_ff == ST_WAVE);
      cmd.scale_en = (state_ff == ST_SCALE);
      cmd.load_en  = (state_ff == ST_LOAD) && !status.out_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/pwg_datapath.sv
// Datapath of the periodic waveform generator: registers, phase accumulator,
// waveform shaping, amplitude scaling and output register. Depends on pwg_pkg
// and the channel interfaces.
module pwg_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pwg_pkg::TICKS_W-1:0]        ticks_elapsed,
   input  pwg_pkg::cmd_type                   cmd,
   output pwg_pkg::status_type                status,
   pwg_csr_if.sink                            csr,
   pwg_rsp_if.source                          rsp
);

   localparam pwg_pkg::sine_tab_type SINE_TAB = pwg_pkg::build_sine_tab();
   localparam int IDXW  = pwg_pkg::TAB_IDX_W;
   localparam int IPW   = 30 + IDXW;

   // Configuration registers
   logic [31:0]        phase_step_ff;
   logic [2:0]         wave_type_ff;
   logic signed [15:0] amplitude_ff;
   logic signed [15:0] average_ff;

   // Pipeline registers
   logic [pwg_pkg::MUL_W-1:0]      mul_ff;
   logic [pwg_pkg::PHASE_BITS-1:0] acc_ff;
   logic signed [16:0]             wave_ff;
   logic signed [32:0]             prod_ff;
   logic signed [15:0]             sample_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;

   // Combinational signals
   logic [pwg_pkg::STEP_W-1:0]     step_aligned;
   logic [pwg_pkg::PHASE_BITS-1:0] acc_in;
   logic [63:0]                    acc_wide;
   logic [31:0]                    p;
   logic [IPW-1:0]                 idx_prod;
   logic [IDXW-1:0]                idx_raw;
   logic [IDXW-1:0]                idx;
   logic [16:0]                    tab_val;
   logic signed [16:0]             sine_val;
   logic [31:0]                    tri_u;
   logic [32:0]                    tri_d;
   logic signed [17:0]             tri_val;
   logic signed [16:0]             wave_in;
   logic signed [33:0]             biased;
   logic signed [17:0]             rounded;
   logic signed [18:0]             offset_sum;
   logic signed [15:0]             sample_in;

   assign csr.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         wave_type_ff  <= '0;
         amplitude_ff  <= '0;
         average_ff    <= '0;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            pwg_pkg::CSR_PHASE_STEP: phase_step_ff <= csr.data;
            pwg_pkg::CSR_WAVE_TYPE:  wave_type_ff  <= csr.data[2:0];
            pwg_pkg::CSR_AMPLITUDE:  amplitude_ff  <= signed'(csr.data[15:0]);
            pwg_pkg::CSR_AVERAGE:    average_ff    <= signed'(csr.data[15:0]);
            default: ;
         endcase
      end
   end

   // Phase increment and accumulation
   assign step_aligned = pwg_pkg::STEP_W'(phase_step_ff >> pwg_pkg::DOWN_SHIFT);
   assign acc_in = acc_ff
                 + pwg_pkg::PHASE_BITS'(64'(mul_ff) << pwg_pkg::UP_SHIFT);

   // Phase as a fraction of 2^32
   assign acc_wide = 64'(acc_ff);
   assign p = 32'((acc_wide >> pwg_pkg::UP_SHIFT) << pwg_pkg::DOWN_SHIFT);

   // Sine: quadrant fold of the quarter-wave table
   assign idx_prod = IPW'(p[29:0]) * IPW'(pwg_pkg::SINE_TABLE_DEPTH);
   assign idx_raw  = idx_prod[30 +: IDXW];
   assign idx      = p[30] ? (IDXW'(pwg_pkg::SINE_TABLE_DEPTH) - idx_raw) : idx_raw;
   assign tab_val  = SINE_TAB[idx];
   assign sine_val = p[31] ? -signed'(tab_val) : signed'(tab_val);

   // Triangle: distance from the peak at quarter cycle
   assign tri_u   = p - 32'h4000_0000;
   assign tri_d   = (tri_u <= 32'h8000_0000) ? {1'b0, tri_u}
                                             : (33'h1_0000_0000 - {1'b0, tri_u});
   assign tri_val = 18'sd32768 - signed'({1'b0, tri_d[31:15]});

   // Waveform select
   always_comb begin
      case (wave_type_ff)
         pwg_pkg::WAVE_SINE:     wave_in = sine_val;
         pwg_pkg::WAVE_SQUARE:   wave_in = p[31] ? -17'sd32768 : 17'sd32768;
         pwg_pkg::WAVE_TRIANGLE: wave_in = tri_val[16:0];
         pwg_pkg::WAVE_SAWTOOTH: wave_in = 17'(signed'(p[31:16]));
         default:                wave_in = '0;
      endcase
   end

   // Round half up, add offset, saturate
   assign biased     = 34'(prod_ff) + 34'sd32768;
   assign rounded    = biased[33:16];
   assign offset_sum = 19'(rounded) + 19'(average_ff);
   always_comb begin
      if (offset_sum > 19'sd32767) begin
         sample_in = 16'sh7fff;
      end else if (offset_sum < -19'sd32768) begin
         sample_in = 16'sh8000;
      end else begin
         sample_in = offset_sum[15:0];
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= pwg_pkg::MUL_W'(ticks_elapsed) * pwg_pkg::MUL_W'(step_aligned);
      end
      if (cmd.wave_en) begin
         wave_ff <= wave_in;
      end
      if (cmd.scale_en) begin
         prod_ff <= 33'(wave_ff) * 33'(amplitude_ff);
      end
      if (cmd.load_en) begin
         sample_ff <= sample_in;
      end
   end

   // Phase state and output valid
   assign out_valid_in = cmd.load_en ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.acc_en) begin
            acc_ff <= acc_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.sample       = sample_ff;
   assign status.out_stall = out_valid_ff && !rsp.ready;

endmodule
